@@ sv/kci_pkg.sv @@
// Shared types, constants and address helper for the keyframe cycle interpolator.
package kci_pkg;

    localparam int MAX_KEYFRAMES = 16;
    localparam int MAX_JOINTS    = 8;
    localparam int MAX_RESULTS   = 8;

    localparam int NJ_MAX  = (MAX_JOINTS < MAX_RESULTS) ? MAX_JOINTS : MAX_RESULTS;
    localparam int FRAME_W = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int FCNT_W  = $clog2(MAX_KEYFRAMES + 1);
    localparam int JOINT_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int NJ_W    = $clog2(NJ_MAX + 1);
    localparam int DEPTH   = MAX_KEYFRAMES * MAX_JOINTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int HOLD_W  = 24;
    localparam int NKF_W   = 5;
    localparam int NJF_W   = 4;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 2;
    localparam int FRAC_W  = 16;

    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(1000);
    localparam logic [NKF_W-1:0]  NKF_RESET  = '0;
    localparam logic [NJF_W-1:0]  NJF_RESET  = NJF_W'(1);

    localparam logic [CIDX_W-1:0] CFG_HOLD_TICKS    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NUM_KEYFRAMES = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_NUM_JOINTS    = 2'd2;

    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_EVALUATE = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic               func;
        logic [31:0]        time_ticks;
        logic [3:0]         frame_index;
        logic [2:0]         write_joint;
        logic signed [31:0] position_value;
    } t_in;

    typedef struct packed {
        logic [2:0]         joint_number;
        logic signed [31:0] position_command;
        logic               last_joint;
    } t_out;

    // Row-major table address: one row of MAX_JOINTS entries per keyframe.
    function automatic t_addr entry_addr(input logic [FRAME_W-1:0] frame,
                                         input logic [JOINT_W-1:0] joint);
        return ADDR_W'(frame) * ADDR_W'(MAX_JOINTS) + ADDR_W'(joint);
    endfunction

endpackage

@@ sv/kci_table.sv @@
// Keyframe position table: one guarded write port and two registered read ports.
module kci_table (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [3:0]           i_wr_frame,
    input  logic [2:0]           i_wr_joint,
    input  logic [31:0]          i_wr_data,
    input  kci_pkg::t_addr       i_rd_a_addr,
    input  kci_pkg::t_addr       i_rd_b_addr,
    output logic [31:0]          o_rd_a,
    output logic [31:0]          o_rd_b
);
    import kci_pkg::*;

    logic [31:0] r_mem [DEPTH];
    logic        wr_ok;
    t_addr       wr_addr;

    // Writes outside the table dimensions are dropped.
    assign wr_ok   = (int'(i_wr_frame) < MAX_KEYFRAMES) && (int'(i_wr_joint) < MAX_JOINTS);
    assign wr_addr = entry_addr(FRAME_W'(i_wr_frame), JOINT_W'(i_wr_joint));

    always_ff @(posedge i_clk) begin
        if (i_we && wr_ok) begin
            r_mem[wr_addr] <= i_wr_data;
        end
        o_rd_a <= r_mem[i_rd_a_addr];
        o_rd_b <= r_mem[i_rd_b_addr];
    end

endmodule

@@ sv/keyframe_cycle_interpolator.sv @@
// Top level of the keyframe cycle interpolator: request sequencer, divider and joint datapath.
//
// A write request (func 0) stores one joint position into the keyframe table in the
// cycle it is accepted. An evaluate request (func 1) with a time in ticks produces one
// position command per joint, joint 0 first, with last_joint set on the final one; with
// no keyframes configured it produces nothing. Each keyframe owns a period of twice the
// hold time: the first half holds the keyframe, the second half moves linearly toward
// the next one (wrapping to keyframe 0), and past the end of the whole cycle keyframe 0
// is held. One request is worked on at a time. An evaluate request is accepted, then
// the period is subtracted repeatedly to find the keyframe, a bit-serial divide forms
// the 16-bit fraction when the time falls in an interpolating half, and each joint in
// turn goes through the table read, multiply and add, waiting while the output stalls.
// The table is a memory with one write port and two read ports, so the current and next
// keyframe entries are read together. Configuration is written through a plain write port;
// the user must write it only while the block is idle, which the block does not enforce.
module keyframe_cycle_interpolator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kci_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [kci_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  kci_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output kci_pkg::t_out               o_out
);
    import kci_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DIV,
        S_READ,
        S_MUL,
        S_ADD
    } t_state;

    // Configuration registers.
    logic [HOLD_W-1:0] r_hold_ticks;
    logic [NKF_W-1:0]  r_num_keyframes;
    logic [NJF_W-1:0]  r_num_joints;

    // Sequencer state and per-request working registers.
    t_state              r_state;
    logic [31:0]         r_phase;
    logic [HOLD_W:0]     r_period;
    logic [HOLD_W-1:0]   r_hold;
    logic [FCNT_W-1:0]   r_frame;
    logic [FCNT_W-1:0]   r_nk;
    logic [FRAME_W-1:0]  r_next;
    logic                r_lerp;
    logic [HOLD_W-1:0]   r_rem;
    logic [FRAC_W-1:0]   r_frac;
    logic [3:0]          r_bitcnt;
    logic [JOINT_W-1:0]  r_joint;
    logic [NJ_W-1:0]     r_nj;
    logic signed [31:0]  r_a;
    logic signed [49:0]  r_prod;
    logic                r_out_valid;
    t_out                r_out;

    logic               in_acc;
    logic               out_free;
    logic [HOLD_W-1:0]  hold_eff;
    logic [FCNT_W-1:0]  nk_eff;
    logic [NJ_W-1:0]    nj_eff;
    logic [FCNT_W-1:0]  next_cnt;
    logic [HOLD_W:0]    rem2;
    logic               rem_ge;
    logic [31:0]        rd_a;
    logic [31:0]        rd_b;
    logic signed [32:0] diff;
    logic signed [49:0] prod_sh;
    logic signed [31:0] cmd;
    logic               joint_last;
    t_addr              rd_a_addr;
    t_addr              rd_b_addr;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Clamp the configuration to the ranges the datapath supports.
    assign hold_eff = (r_hold_ticks == '0) ? HOLD_W'(1) : r_hold_ticks;
    assign nk_eff   = (int'(r_num_keyframes) > MAX_KEYFRAMES) ? FCNT_W'(MAX_KEYFRAMES)
                                                              : FCNT_W'(r_num_keyframes);
    always_comb begin
        if (r_num_joints == '0) begin
            nj_eff = NJ_W'(1);
        end else if (int'(r_num_joints) > NJ_MAX) begin
            nj_eff = NJ_W'(NJ_MAX);
        end else begin
            nj_eff = NJ_W'(r_num_joints);
        end
    end

    assign next_cnt = r_frame + FCNT_W'(1);

    // One restoring-division step per cycle: the remainder stays below the hold time.
    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = rem2 >= {1'b0, r_hold};

    // The table is read at the current and next keyframe for the joint in progress.
    assign rd_a_addr = entry_addr(FRAME_W'(r_frame), r_joint);
    assign rd_b_addr = entry_addr(r_next, r_joint);

    kci_table u_table (
        .i_clk       (i_clk),
        .i_we        (in_acc && (i_in.func == FUNC_WRITE)),
        .i_wr_frame  (i_in.frame_index),
        .i_wr_joint  (i_in.write_joint),
        .i_wr_data   (i_in.position_value),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (rd_b_addr),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    // Outside the interpolating half the difference is forced to zero, so the
    // command falls back to the current keyframe entry.
    assign diff    = r_lerp ? ($signed({rd_b[31], rd_b}) - $signed({rd_a[31], rd_a}))
                            : 33'sd0;
    // The arithmetic shift floors the scaled difference toward minus infinity.
    assign prod_sh = r_prod >>> FRAC_W;
    assign cmd     = r_a + prod_sh[31:0];

    assign joint_last = (NJ_W'(r_joint) + NJ_W'(1)) == r_nj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks    <= HOLD_RESET;
            r_num_keyframes <= NKF_RESET;
            r_num_joints    <= NJF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOLD_TICKS:    r_hold_ticks    <= i_cfg_data[HOLD_W-1:0];
                CFG_NUM_KEYFRAMES: r_num_keyframes <= i_cfg_data[NKF_W-1:0];
                CFG_NUM_JOINTS:    r_num_joints    <= i_cfg_data[NJF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The output register is refilled by the add stage or emptied once taken.
            if ((r_state == S_ADD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in.func == FUNC_EVALUATE) && (nk_eff != '0)) begin
                        r_phase  <= i_in.time_ticks;
                        r_hold   <= hold_eff;
                        r_period <= {hold_eff, 1'b0};
                        r_nk     <= nk_eff;
                        r_nj     <= nj_eff;
                        r_frame  <= '0;
                        r_joint  <= '0;
                        r_frac   <= '0;
                        r_state  <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (r_frame == r_nk) begin
                        // Time lies past the whole cycle: hold keyframe 0.
                        r_frame <= '0;
                        r_next  <= '0;
                        r_lerp  <= 1'b0;
                        r_state <= S_READ;
                    end else if (r_phase >= 32'(r_period)) begin
                        r_phase <= r_phase - 32'(r_period);
                        r_frame <= next_cnt;
                    end else begin
                        r_next <= (next_cnt == r_nk) ? '0 : FRAME_W'(next_cnt);
                        if (r_phase >= 32'(r_hold)) begin
                            r_lerp   <= 1'b1;
                            r_rem    <= HOLD_W'(r_phase - 32'(r_hold));
                            r_bitcnt <= '0;
                            r_state  <= S_DIV;
                        end else begin
                            r_lerp  <= 1'b0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_DIV: begin
                    r_rem    <= rem_ge ? HOLD_W'(rem2 - {1'b0, r_hold}) : HOLD_W'(rem2);
                    r_frac   <= {r_frac[FRAC_W-2:0], rem_ge};
                    r_bitcnt <= r_bitcnt + 4'd1;
                    if (r_bitcnt == 4'(FRAC_W - 1)) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_a     <= $signed(rd_a);
                    r_prod  <= diff * $signed({1'b0, r_frac});
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (out_free) begin
                        r_out.joint_number     <= 3'(r_joint);
                        r_out.position_command <= cmd;
                        r_out.last_joint       <= joint_last;
                        if (joint_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_joint <= r_joint + JOINT_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the keyframe cycle interpolator: directed script, then random phases.
module tb_top;
    import kci_pkg::*;

    // The register file only decodes three indexes; this one must be ignored.
    localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int SETTLE_CYCLES   = 80;   // covers the slowest evaluate
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 35;
    localparam int PRESSURE_PHASE  = 2;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef enum logic {ROW_REG, ROW_REQ} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CIDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]   reg_val;
        t_in                req;
        bit                 typed;
        logic signed [31:0] typed_pos;
    } t_script_row;

    logic                i_clk        = 1'b0;
    logic                r_rst_n      = 1'b0;
    logic                r_cfg_we     = 1'b0;
    logic [CIDX_W-1:0]   r_cfg_index  = '0;
    logic [CFG_W-1:0]    r_cfg_data   = '0;
    logic                r_in_valid   = 1'b0;
    t_in                 r_in         = '0;
    logic                r_out_stall  = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out                o_out;

    // Stimulus shaping controls.
    int unsigned         idle_pct     = 0;
    int unsigned         stall_pct    = 0;
    logic                hold_off     = 1'b0;
    logic                pressure_go  = 1'b0;

    // Local copy of the block's state and registers.
    logic signed [31:0]  kf_pos [MAX_KEYFRAMES][MAX_JOINTS];
    bit                  loaded [MAX_KEYFRAMES][MAX_JOINTS];
    logic [HOLD_W-1:0]   hold_reg = HOLD_RESET;
    logic [NKF_W-1:0]    nkf_reg  = NKF_RESET;
    logic [NJF_W-1:0]    nj_reg   = NJF_RESET;

    t_out                cmd_expected [$];
    int                  n_mismatch = 0;
    t_script_row         script [$];

    keyframe_cycle_interpolator dut (
        .i_clk       (i_clk),
        .i_rst_n     (r_rst_n),
        .i_cfg_we    (r_cfg_we),
        .i_cfg_index (r_cfg_index),
        .i_cfg_data  (r_cfg_data),
        .i_in_valid  (r_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (r_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (r_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Effective register values, with out-of-range settings folded as the block does.
    function automatic longint unsigned eff_hold();
        return (hold_reg == 0) ? 1 : hold_reg;
    endfunction

    function automatic int unsigned eff_frames();
        return (nkf_reg > MAX_KEYFRAMES) ? MAX_KEYFRAMES : nkf_reg;
    endfunction

    function automatic int unsigned eff_joints();
        if (nj_reg == 0) return 1;
        if (nj_reg > NJ_MAX) return NJ_MAX;
        return nj_reg;
    endfunction

    // Applies one accepted request: a write updates the table, an evaluate
    // queues one position command per joint.
    function automatic void apply_request(input t_in req);
        longint unsigned hold, period, t, frame, nxt, ph, frac;
        int unsigned     nk, nj, j;
        bit              lerp;
        longint          a, b, cmd;
        t_out            res;
        if (req.func == FUNC_WRITE) begin
            kf_pos[req.frame_index][req.write_joint] = req.position_value;
            loaded[req.frame_index][req.write_joint] = 1'b1;
            return;
        end
        nk = eff_frames();
        if (nk == 0) return;
        nj = eff_joints();
        hold = eff_hold();
        period = 2 * hold;
        t = req.time_ticks;
        frame = 0;
        nxt = 0;
        lerp = 1'b0;
        frac = 0;
        // Past the end of the cycle keyframe 0 is held.
        if (t < period * nk) begin
            ph = t % period;
            frame = t / period;
            nxt = (frame + 1) % nk;
            lerp = (ph >= hold);
            if (lerp) frac = ((ph - hold) << 16) / hold;
        end
        for (j = 0; j < nj; j++) begin
            a = kf_pos[frame][j];
            cmd = a;
            if (lerp) begin
                b = kf_pos[nxt][j];
                // Arithmetic shift gives the floor of the scaled difference.
                cmd = a + (((b - a) * longint'(frac)) >>> 16);
            end
            res.joint_number = 3'(j);
            res.position_command = cmd[31:0];
            res.last_joint = (j == nj - 1);
            cmd_expected.push_back(res);
        end
    endfunction

    function automatic t_script_row reg_row(input logic [CIDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] val);
        t_script_row r;
        r = '{kind: ROW_REG, reg_idx: idx, reg_val: val, req: '0, typed: 1'b0, typed_pos: '0};
        return r;
    endfunction

    function automatic t_script_row write_row(input logic [3:0] frame, input logic [2:0] joint,
                                              input logic signed [31:0] pos);
        t_script_row r;
        r = '{kind: ROW_REQ, reg_idx: '0, reg_val: '0, req: '0, typed: 1'b0, typed_pos: '0};
        r.req.func = FUNC_WRITE;
        r.req.time_ticks = 32'hA5A5_5A5A;
        r.req.frame_index = frame;
        r.req.write_joint = joint;
        r.req.position_value = pos;
        return r;
    endfunction

    function automatic t_script_row eval_row(input logic [31:0] t, input bit typed,
                                             input logic signed [31:0] pos);
        t_script_row r;
        r = '{kind: ROW_REQ, reg_idx: '0, reg_val: '0, req: '0, typed: typed, typed_pos: pos};
        r.req.func = FUNC_EVALUATE;
        r.req.time_ticks = t;
        r.req.frame_index = 4'hF;
        r.req.write_joint = 3'h7;
        r.req.position_value = 32'h5A5A_A5A5;
        return r;
    endfunction

    // Random request. Evaluate times cluster on the cycle so that holds,
    // ramps, period edges and the wrap are all hit.
    function automatic t_in random_request(input bit is_write);
        t_in               req;
        longint unsigned   h, span;
        int unsigned       nk, roll;
        req.func = is_write ? FUNC_WRITE : FUNC_EVALUATE;
        req.time_ticks = $urandom();
        req.frame_index = 4'($urandom_range(15, 0));
        req.write_joint = 3'($urandom_range(7, 0));
        req.position_value = $urandom();
        if (is_write) begin
            case ($urandom_range(9, 0))
                0: req.position_value = 32'h7FFF_FFFF;
                1: req.position_value = 32'h8000_0000;
                2: req.position_value = '0;
                default: ;
            endcase
        end else begin
            nk = eff_frames();
            h = eff_hold();
            span = 2 * h * nk;
            roll = $urandom_range(99, 0);
            if (roll < 10 || span == 0)
                req.time_ticks = $urandom();
            else if (roll < 30)
                req.time_ticks = 32'($urandom_range(2 * nk, 0) * h + $urandom_range(2, 0) - 1);
            else
                req.time_ticks = $urandom_range(32'(span - 1), 0);
        end
        return req;
    endfunction

    // Offers one request, with random idle cycles ahead of it, and returns in
    // the time step of the edge that accepted it.
    task automatic push_request(input t_in req);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            r_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        r_in_valid <= 1'b1;
        r_in <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic issue(input t_in req);
        push_request(req);
        apply_request(req);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        r_cfg_we <= 1'b1;
        r_cfg_index <= idx;
        r_cfg_data <= val;
        @(posedge i_clk);
        r_cfg_we <= 1'b0;
        case (idx)
            CFG_HOLD_TICKS:    hold_reg = val[HOLD_W-1:0];
            CFG_NUM_KEYFRAMES: nkf_reg = val[NKF_W-1:0];
            CFG_NUM_JOINTS:    nj_reg = val[NJF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stops offering requests and waits until the block is idle. Evaluates
    // with no keyframes give no command, so a fixed tail covers them.
    task automatic drain();
        r_in_valid <= 1'b0;
        stall_pct <= 0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes every entry that the current settings can read but that has not
    // been written yet, so no evaluate ever reads an undefined entry.
    task automatic load_missing_entries();
        t_in req;
        for (int f = 0; f < eff_frames(); f++) begin
            for (int j = 0; j < eff_joints(); j++) begin
                if (!loaded[f][j]) begin
                    req = random_request(1'b1);
                    req.frame_index = 4'(f);
                    req.write_joint = 3'(j);
                    issue(req);
                end
            end
        end
    endtask

    // Receiver stall: random per phase, forced high during the hold-off.
    always @(posedge i_clk) begin
        r_out_stall <= hold_off || (stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
    end

    // Long receiver hold-off: the sender keeps offering, so the block backs up
    // and must stall its request side.
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Checks each accepted command against the oldest expected one.
    always @(posedge i_clk) begin
        t_out want;
        if (r_rst_n && o_out_valid && !r_out_stall) begin
            if (cmd_expected.size() == 0) begin
                $display("%0t: unexpected command: expected none, got joint %0d pos %0d last %0b",
                         $time, o_out.joint_number, o_out.position_command, o_out.last_joint);
                n_mismatch++;
            end else begin
                want = cmd_expected.pop_front();
                if (o_out.joint_number !== want.joint_number ||
                    o_out.position_command !== want.position_command ||
                    o_out.last_joint !== want.last_joint) begin
                    $display("%0t: mismatch: expected joint %0d pos %0d last %0b, got joint %0d pos %0d last %0b",
                             $time, want.joint_number, want.position_command, want.last_joint,
                             o_out.joint_number, o_out.position_command, o_out.last_joint);
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        t_script_row       row;
        t_out              typed_res;
        logic [CFG_W-1:0]  hv, kv, jv;

        // Directed script. Typed positions are the ones obvious from the
        // cycle: holds, the start of a ramp, and the hold past the cycle end.
        script.push_back(eval_row(32'd0, 1'b0, '0));                    // no keyframes yet
        script.push_back(write_row(4'd0, 3'd0, 32'sh7FFF_FFFF));
        script.push_back(write_row(4'd1, 3'd0, 32'sh8000_0000));
        script.push_back(write_row(4'd15, 3'd7, 32'sh0000_0001));
        script.push_back(reg_row(CFG_NUM_KEYFRAMES, 24'd2));
        script.push_back(eval_row(32'd0, 1'b1, 32'sh7FFF_FFFF));
        script.push_back(eval_row(32'd999, 1'b1, 32'sh7FFF_FFFF));
        script.push_back(eval_row(32'd1000, 1'b1, 32'sh7FFF_FFFF));     // ramp starts at a
        script.push_back(eval_row(32'd1500, 1'b0, '0));                 // full-range ramp
        script.push_back(eval_row(32'd2000, 1'b1, 32'sh8000_0000));
        script.push_back(eval_row(32'd3999, 1'b0, '0));                 // wraps toward frame 0
        script.push_back(eval_row(32'd4000, 1'b1, 32'sh7FFF_FFFF));     // cycle over
        script.push_back(eval_row(32'hFFFF_FFFF, 1'b1, 32'sh7FFF_FFFF));
        script.push_back(reg_row(CFG_HOLD_TICKS, 24'd0));               // zero hold acts as one
        script.push_back(eval_row(32'd1, 1'b1, 32'sh7FFF_FFFF));
        script.push_back(eval_row(32'd3, 1'b1, 32'sh8000_0000));
        script.push_back(eval_row(32'd4, 1'b1, 32'sh7FFF_FFFF));
        script.push_back(reg_row(CFG_HOLD_TICKS, 24'hFF_FFFF));
        script.push_back(eval_row(32'd25165822, 1'b0, '0));
        script.push_back(eval_row(32'd67108859, 1'b0, '0));             // last tick of cycle
        script.push_back(reg_row(CFG_SPARE, 24'hFF_FFFF));              // ignored index
        script.push_back(reg_row(CFG_NUM_JOINTS, 24'd0));               // zero joints acts as one
        script.push_back(eval_row(32'd2000, 1'b1, 32'sh7FFF_FFFF));
        script.push_back(reg_row(CFG_NUM_KEYFRAMES, 24'd0));
        script.push_back(eval_row(32'd5, 1'b0, '0));

        repeat (7) @(posedge i_clk);
        r_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_REG) begin
                drain();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                push_request(row.req);
                if (row.typed) begin
                    typed_res.joint_number = 3'd0;
                    typed_res.position_command = row.typed_pos;
                    typed_res.last_joint = 1'b1;
                    cmd_expected.push_back(typed_res);
                end else begin
                    apply_request(row.req);
                end
            end
        end

        // Random phases, each under its own settings and idling pattern.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    hv = CFG_W'($urandom_range(8, 1));
                    kv = CFG_W'($urandom_range(4, 1));
                    jv = CFG_W'($urandom_range(3, 1));
                end
                1: begin
                    // Oversized counts fold to the maximum.
                    hv = '0;
                    kv = CFG_W'($urandom_range(31, 17));
                    jv = CFG_W'($urandom_range(15, 9));
                end
                2: begin
                    hv = 24'hFF_FFFF;
                    kv = CFG_W'(MAX_KEYFRAMES);
                    jv = CFG_W'(NJ_MAX);
                end
                3: begin
                    hv = CFG_W'(1);
                    kv = CFG_W'(1);
                    jv = '0;
                end
                4: begin
                    hv = CFG_W'($urandom_range(5000, 1));
                    kv = '0;
                    jv = CFG_W'($urandom_range(8, 1));
                end
                default: begin
                    hv = ($urandom_range(1, 0) != 0) ? CFG_W'($urandom_range(20, 1))
                                                     : CFG_W'($urandom_range(24'hFF_FFFF, 1));
                    kv = CFG_W'($urandom_range(16, 1));
                    jv = CFG_W'($urandom_range(15, 0));
                end
            endcase
            write_reg(CFG_HOLD_TICKS, hv);
            write_reg(CFG_NUM_KEYFRAMES, kv);
            write_reg(CFG_NUM_JOINTS, jv);

            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 54; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 54; end
                default: begin idle_pct = 12; stall_pct <= 12; end
            endcase
            if (phase == PRESSURE_PHASE) pressure_go <= 1'b1;

            load_missing_entries();
            repeat (ITEMS_PER_PHASE) issue(random_request($urandom_range(99, 0) < 35));
        end

        drain();
        if (n_mismatch == 0 && cmd_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/kci_pkg.sv
sv/kci_table.sv
sv/keyframe_cycle_interpolator.sv
tb/tb_top.sv
